### hdl/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types and constants for the text cursor glyph renderer.
// ----------------------------------------------------------------------------
package trc_pkg;

  localparam int PANEL_WIDTH_D  = 176;
  localparam int PANEL_HEIGHT_D = 264;
  localparam int GLYPH_COUNT_D  = 256;

  localparam int CUR_W   = 15;
  localparam int COORD_W = 11;
  localparam int ADDR_W  = 13;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CUR_W-1:0] CURSOR_MAX = 15'h7FFF;
  localparam logic [CUR_W-1:0] ADVANCE_X  = 15'd6;
  localparam logic [CUR_W-1:0] ADVANCE_Y  = 15'd8;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] LAT_PFX0   = 8'd194;
  localparam logic [7:0] LAT_PFX1   = 8'd195;
  localparam logic [7:0] LAT_LO     = 8'd131;
  localparam logic [7:0] LAT_HI     = 8'd191;
  localparam logic [7:0] LAT_DEG    = 8'd176;
  localparam logic [7:0] LAT_OFS    = 8'd64;

  typedef enum logic [1:0] {
    MODE_CHAR = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATION = 2'd0,
    REG_TEXT_COL = 2'd1,
    REG_BACK_COL = 2'd2,
    REG_WRAP     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       rotation;
    logic [CFG_W-1:0] text_color;
    logic [CFG_W-1:0] back_color;
    logic             wrap_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         code;
    logic               do_draw;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ADDR_W-1:0]  address;
    logic [7:0]         data_byte;
    logic [CUR_W-1:0]   cur_col;
    logic [CUR_W-1:0]   cur_row;
  } cmd_t;

  function automatic logic [CUR_W-1:0] sat_add(logic [CUR_W-1:0] a, logic [CUR_W-1:0] b);
    logic [CUR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CUR_W] ? CURSOR_MAX : s[CUR_W-1:0];
  endfunction

endpackage

### hdl/trc_if.sv
// ----------------------------------------------------------------------------
// trc_in_if / trc_out_if
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
interface trc_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic [7:0]                 char_code;
  logic                       map_latin;
  logic [trc_pkg::ADDR_W-1:0] address;
  logic [7:0]                 data_byte;
  modport source (output valid, mode, char_code, map_latin, address, data_byte, input ready);
  modport sink   (input valid, mode, char_code, map_latin, address, data_byte, output ready);
endinterface

interface trc_out_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                read_data;
  logic [trc_pkg::CUR_W-1:0] cursor_col;
  logic [trc_pkg::CUR_W-1:0] cursor_row;
  logic                      drawn;
  modport source (output valid, read_data, cursor_col, cursor_row, drawn, input ready);
  modport sink   (input valid, read_data, cursor_col, cursor_row, drawn, output ready);
endinterface

### hdl/trc_front.sv
// ----------------------------------------------------------------------------
// trc_front
// Accepts words, applies Latin mapping, advances the cursor, issues commands.
// ----------------------------------------------------------------------------
module trc_front #(
  parameter int PANEL_WIDTH  = trc_pkg::PANEL_WIDTH_D,
  parameter int PANEL_HEIGHT = trc_pkg::PANEL_HEIGHT_D
) (
  input  logic          clk,
  input  logic          rst_n,
  input  trc_pkg::cfg_t cfg,
  input  logic          blocked,
  input  logic          q_full,
  trc_in_if.sink        in_ch,
  output logic          push,
  output trc_pkg::cmd_t cmd
);
  localparam logic [trc_pkg::CUR_W-1:0] LW0 = trc_pkg::CUR_W'(PANEL_WIDTH);
  localparam logic [trc_pkg::CUR_W-1:0] LH0 = trc_pkg::CUR_W'(PANEL_HEIGHT);

  logic [trc_pkg::CUR_W-1:0] col_r, col_nxt, row_r, row_nxt, colw, roww, lw, lh;
  logic [7:0] code;
  logic skip, do_draw;

  assign in_ch.ready = !q_full && !blocked;
  assign push        = in_ch.valid && in_ch.ready;
  assign lw = cfg.rotation[0] ? LH0 : LW0;
  assign lh = cfg.rotation[0] ? LW0 : LH0;

  always_comb begin
    code = in_ch.char_code;
    skip = 1'b0;
    if (in_ch.map_latin) begin
      if (code == trc_pkg::LAT_PFX0 || code == trc_pkg::LAT_PFX1) begin
        skip = 1'b1;
      end else if (code > trc_pkg::LAT_LO && code < trc_pkg::LAT_HI &&
                   code != trc_pkg::LAT_DEG) begin
        code = code + trc_pkg::LAT_OFS;
      end
    end
    col_nxt = col_r;
    row_nxt = row_r;
    colw    = col_r;
    roww    = row_r;
    do_draw = 1'b0;
    if (in_ch.mode == trc_pkg::MODE_CHAR && !skip) begin
      if (code == trc_pkg::CH_NEWLINE) begin
        col_nxt = '0;
        row_nxt = trc_pkg::sat_add(row_r, trc_pkg::ADVANCE_Y);
      end else if (code != trc_pkg::CH_CR) begin
        if (cfg.wrap_enable &&
            ({1'b0, col_r} + {1'b0, trc_pkg::ADVANCE_X}) > {1'b0, lw}) begin
          colw = '0;
          roww = trc_pkg::sat_add(row_r, trc_pkg::ADVANCE_Y);
        end
        do_draw = (colw < lw) && (roww < lh);
        col_nxt = trc_pkg::sat_add(colw, trc_pkg::ADVANCE_X);
        row_nxt = roww;
      end
    end
    cmd.mode      = in_ch.mode;
    cmd.code      = code;
    cmd.do_draw   = do_draw;
    cmd.x         = colw[trc_pkg::COORD_W-1:0];
    cmd.y         = roww[trc_pkg::COORD_W-1:0];
    cmd.address   = in_ch.address;
    cmd.data_byte = in_ch.data_byte;
    cmd.cur_col   = col_nxt;
    cmd.cur_row   = row_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end
endmodule

### hdl/trc_fifo.sv
// ----------------------------------------------------------------------------
// trc_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module trc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  trc_pkg::cmd_t wdata,
  input  logic          pop,
  output trc_pkg::cmd_t rdata,
  output logic          full,
  output logic          not_empty
);
  trc_pkg::cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r[1];
  assign not_empty = cnt_r != 2'd0;
  assign rdata     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

### hdl/trc_back.sv
// ----------------------------------------------------------------------------
// trc_back
// Executes commands: glyph loads, framebuffer reads and glyph drawing.
// ----------------------------------------------------------------------------
module trc_back #(
  parameter int PANEL_WIDTH  = trc_pkg::PANEL_WIDTH_D,
  parameter int PANEL_HEIGHT = trc_pkg::PANEL_HEIGHT_D,
  parameter int GLYPH_COUNT  = trc_pkg::GLYPH_COUNT_D
) (
  input  logic          clk,
  input  logic          rst_n,
  input  trc_pkg::cfg_t cfg,
  input  logic          q_avail,
  input  trc_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          clearing,
  trc_out_if.source     out_ch
);
  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int FRAME_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int FA_W        = $clog2(FRAME_BYTES);
  localparam int GLYPH_BYTES = GLYPH_COUNT * 5;
  localparam int GA_W        = (GLYPH_BYTES > 1) ? $clog2(GLYPH_BYTES) : 1;
  localparam int CW          = trc_pkg::COORD_W;
  localparam logic [CW-1:0] W0 = CW'(PANEL_WIDTH);
  localparam logic [CW-1:0] H0 = CW'(PANEL_HEIGHT);

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_GRD   = 9'b000000100,
    S_PCALC = 9'b000001000,
    S_PRD   = 9'b000010000,
    S_PMOD  = 9'b000100000,
    S_FRD   = 9'b001000000,
    S_FWT   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0] glyph_mem [GLYPH_BYTES];
  logic [7:0] frame_mem [FRAME_BYTES];
  logic [7:0] glyph_q_r, frame_q_r;

  trc_pkg::cmd_t cmd_r;
  logic [FA_W-1:0] clr_r, pix_idx_r, f_addr;
  logic [7:0] pix_mask_r, rd_data_r, f_wdata;
  logic pix_clr_r, f_we;
  logic [2:0] ci_r, rj_r;
  logic out_valid_r, out_free;
  logic [7:0] line;
  logic [10:0] g_full;
  logic [GA_W-1:0] g_addr;
  logic [CW-1:0] x, y, lw, lh, px, py;
  logic [23:0] idx;
  logic bit_on, pix_go, last_pix;

  assign clearing = state_r == S_CLR;
  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = state_r == S_IDLE && q_avail;
  assign out_ch.valid = out_valid_r;

  assign g_full = 11'(cmd_r.code) * 11'd5 + 11'(ci_r);
  assign g_addr = GA_W'(g_full);
  assign line   = (32'(cmd_r.code) < GLYPH_COUNT) ? glyph_q_r : 8'h00;

  always_comb begin
    lw = cfg.rotation[0] ? H0 : W0;
    lh = cfg.rotation[0] ? W0 : H0;
    x  = cmd_r.x + CW'(ci_r);
    y  = cmd_r.y + CW'(rj_r);
    case (cfg.rotation)
      2'd1: begin px = W0 - 1'b1 - y; py = x; end
      2'd2: begin px = W0 - 1'b1 - x; py = H0 - 1'b1 - y; end
      2'd3: begin px = y; py = H0 - 1'b1 - x; end
      default: begin px = x; py = y; end
    endcase
    idx    = 24'(py) * 24'(ROW_BYTES) + 24'(px >> 3);
    bit_on = line[rj_r];
    pix_go = x < lw && y < lh && 32'(idx) < FRAME_BYTES &&
             (bit_on || cfg.back_color != cfg.text_color);
    last_pix = rj_r == 3'd7 && ci_r == 3'd4;
  end

  always_comb begin
    f_addr  = pix_idx_r;
    f_we    = 1'b0;
    f_wdata = pix_clr_r ? (frame_q_r & ~pix_mask_r) : (frame_q_r | pix_mask_r);
    case (state_r)
      S_CLR: begin
        f_addr  = clr_r;
        f_we    = 1'b1;
        f_wdata = 8'hFF;
      end
      S_FRD, S_FWT: f_addr = FA_W'(cmd_r.address);
      S_PMOD: f_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    glyph_q_r <= glyph_mem[g_addr];
    frame_q_r <= frame_mem[f_addr];
    if (f_we) frame_mem[f_addr] <= f_wdata;
    if (pop && q_cmd.mode == trc_pkg::MODE_LOAD && 32'(q_cmd.address) < GLYPH_BYTES) begin
      glyph_mem[GA_W'(q_cmd.address)] <= q_cmd.data_byte;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:   if (32'(clr_r) == FRAME_BYTES - 1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (q_avail) begin
          if (q_cmd.mode == trc_pkg::MODE_CHAR && q_cmd.do_draw) state_nxt = S_GRD;
          else if (q_cmd.mode == trc_pkg::MODE_READ && 32'(q_cmd.address) < FRAME_BYTES)
            state_nxt = S_FRD;
          else state_nxt = S_DONE;
        end
      end
      S_GRD:   state_nxt = S_PCALC;
      S_PCALC: begin
        if (pix_go) state_nxt = S_PRD;
        else if (last_pix) state_nxt = S_DONE;
        else if (rj_r == 3'd7) state_nxt = S_GRD;
      end
      S_PRD:   state_nxt = S_PMOD;
      S_PMOD: begin
        if (last_pix) state_nxt = S_DONE;
        else if (rj_r == 3'd7) state_nxt = S_GRD;
        else state_nxt = S_PCALC;
      end
      S_FRD:   state_nxt = S_FWT;
      S_FWT:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r     <= q_cmd;
      ci_r      <= 3'd0;
      rj_r      <= 3'd0;
      rd_data_r <= 8'h00;
    end
    if (state_r == S_PCALC) begin
      pix_idx_r  <= FA_W'(idx);
      pix_mask_r <= 8'h80 >> px[2:0];
      pix_clr_r  <= bit_on ? (cfg.text_color != '0) : (cfg.back_color != '0);
    end
    if ((state_r == S_PCALC && !pix_go) || state_r == S_PMOD) begin
      if (rj_r == 3'd7) begin
        rj_r <= 3'd0;
        ci_r <= ci_r + 3'd1;
      end else begin
        rj_r <= rj_r + 3'd1;
      end
    end
    if (state_r == S_FWT) rd_data_r <= frame_q_r;
    if (state_r == S_DONE && out_free) begin
      out_ch.read_data  <= rd_data_r;
      out_ch.cursor_col <= cmd_r.cur_col;
      out_ch.cursor_row <= cmd_r.cur_row;
      out_ch.drawn      <= cmd_r.mode == trc_pkg::MODE_CHAR && cmd_r.do_draw;
    end
  end
endmodule

### hdl/text_cursor_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_cursor_glyph_renderer
// Draws 5x8 glyphs into a 1-bit framebuffer at a text cursor.
// ----------------------------------------------------------------------------
// Words enter on in_ch (valid/ready) and one result word per input leaves on
// out_ch. Mode 0 draws a character, mode 1 loads a glyph byte, mode 2 reads a
// framebuffer byte. The front updates the cursor as a word is accepted and
// hands a command through a two-entry queue to the back, which owns the
// glyph and framebuffer memories.
// A drawn glyph is handled column by column: the column's glyph byte is read,
// then each of its 8 pixels is a read-modify-write on the single framebuffer
// port, 40 pixels in all; clipped pixels, and background pixels when both
// colours are equal, skip the framebuffer read and write.
// After reset the framebuffer is set to all ones, one byte a cycle; in_ch.ready
// stays low meanwhile. Config writes on cfg_* are taken at any time.
// If out_ch stalls, the result register holds, the back waits and the queue
// fills; then in_ch.ready drops.
// ----------------------------------------------------------------------------
module text_cursor_glyph_renderer #(
  parameter int PANEL_WIDTH  = trc_pkg::PANEL_WIDTH_D,
  parameter int PANEL_HEIGHT = trc_pkg::PANEL_HEIGHT_D,
  parameter int GLYPH_COUNT  = trc_pkg::GLYPH_COUNT_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [trc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trc_pkg::CFG_W-1:0]     cfg_wdata,
  trc_in_if.sink                        in_ch,
  trc_out_if.source                     out_ch
);
  trc_pkg::cfg_t cfg_r;
  trc_pkg::cmd_t f_cmd, q_cmd;
  logic push, pop, q_full, q_avail, clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation    <= 2'd0;
      cfg_r.text_color  <= 16'h0000;
      cfg_r.back_color  <= 16'hFFFF;
      cfg_r.wrap_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        trc_pkg::REG_ROTATION: cfg_r.rotation    <= cfg_wdata[1:0];
        trc_pkg::REG_TEXT_COL: cfg_r.text_color  <= cfg_wdata;
        trc_pkg::REG_BACK_COL: cfg_r.back_color  <= cfg_wdata;
        trc_pkg::REG_WRAP:     cfg_r.wrap_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  trc_front #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .blocked(clearing), .q_full(q_full),
    .in_ch(in_ch), .push(push), .cmd(f_cmd)
  );

  trc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(f_cmd), .pop(pop),
    .rdata(q_cmd), .full(q_full), .not_empty(q_avail)
  );

  trc_back #(
    .PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT), .GLYPH_COUNT(GLYPH_COUNT)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_avail(q_avail), .q_cmd(q_cmd),
    .pop(pop), .clearing(clearing), .out_ch(out_ch)
  );
endmodule

### hdl/trc_checker.sv
// ----------------------------------------------------------------------------
// trc_checker
// Port-level assertions for the renderer, bound to the top level.
// ----------------------------------------------------------------------------
module trc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [7:0]                read_data,
  input logic [trc_pkg::CUR_W-1:0] cursor_col,
  input logic                      drawn
);
  a_no_ready_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");
  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(cursor_col))
    else $error("stalled result word changed");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && drawn |-> read_data == 8'h00)
    else $error("drawn word carries read data");
endmodule

bind text_cursor_glyph_renderer trc_checker u_trc_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .read_data(out_ch.read_data),
  .cursor_col(out_ch.cursor_col), .drawn(out_ch.drawn)
);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text cursor glyph renderer.
// ----------------------------------------------------------------------------
// Drives words on in_ch and compares every result word on out_ch with a
// behavioural model of the cursor, glyph store and framebuffer kept here.
// A short table of directed words comes first, then random phases under
// several register settings and idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import trc_pkg::*;

  localparam int PW       = PANEL_WIDTH_D;
  localparam int PH       = PANEL_HEIGHT_D;
  localparam int ROW_B    = (PW + 7) / 8;
  localparam int FRAME_B  = ROW_B * PH;
  localparam int GLYPH_B  = GLYPH_COUNT_D * 5;
  localparam int CUR_TOP  = 32767;
  localparam int LIMIT    = 3000000;
  localparam int N_RANDOM = 70;

  typedef struct {
    logic [1:0]        mode;
    logic [7:0]        char_code;
    logic              map_latin;
    logic [ADDR_W-1:0] address;
    logic [7:0]        data_byte;
  } word_t;

  typedef struct {
    logic [7:0]       read_data;
    logic [CUR_W-1:0] cursor_col;
    logic [CUR_W-1:0] cursor_row;
    logic             drawn;
  } result_t;

  typedef struct {
    word_t   w;
    bit      typed;
    result_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  trc_in_if  in_ch();
  trc_out_if out_ch();

  text_cursor_glyph_renderer dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  // model state
  logic [7:0] frame_m [FRAME_B];
  logic [7:0] glyph_m [GLYPH_B];
  bit         glyph_set [GLYPH_B];
  int         col_m, row_m;
  logic [1:0] rot_m;
  int         fg_m, bg_m;
  bit         wrap_m;

  result_t pending_q[$];
  int errors;
  int cycles;
  int send_idle_pct, recv_stall_pct;
  row_t table_q[$];
  int pool[] = '{0, 32, 65, 66, 97, 127, 128, 131, 132, 176, 191, 196, 200, 240, 254, 255};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int sat(int v);
    return (v > CUR_TOP) ? CUR_TOP : v;
  endfunction

  function automatic int log_w();
    return rot_m[0] ? PH : PW;
  endfunction

  function automatic int log_h();
    return rot_m[0] ? PW : PH;
  endfunction

  function automatic void plot(int x, int y, int colour);
    int px, py, idx;
    logic [7:0] mask;
    if (x >= log_w() || y >= log_h()) return;
    case (rot_m)
      2'd1: begin px = PW - 1 - y; py = x; end
      2'd2: begin px = PW - 1 - x; py = PH - 1 - y; end
      2'd3: begin px = y; py = PH - 1 - x; end
      default: begin px = x; py = y; end
    endcase
    idx = py * ROW_B + px / 8;
    if (idx >= FRAME_B) return;
    mask = 8'h80 >> (px % 8);
    if (colour != 0) frame_m[idx] = frame_m[idx] & ~mask;
    else frame_m[idx] = frame_m[idx] | mask;
  endfunction

  function automatic bit render_glyph(int x, int y, int code);
    logic [7:0] line;
    if (x >= log_w() || y >= log_h()) return 1'b0;
    for (int i = 0; i < 5; i++) begin
      line = (code < GLYPH_COUNT_D) ? glyph_m[code * 5 + i] : 8'h00;
      for (int j = 0; j < 8; j++) begin
        if (line[j]) plot(x + i, y + j, fg_m);
        else if (bg_m != fg_m) plot(x + i, y + j, bg_m);
      end
    end
    return 1'b1;
  endfunction

  function automatic result_t predict_word(word_t w);
    result_t r;
    int code;
    bit skip;
    r.read_data = 8'h00;
    r.drawn = 1'b0;
    code = w.char_code;
    if (w.mode == MODE_CHAR) begin
      skip = 1'b0;
      if (w.map_latin) begin
        if (w.char_code == LAT_PFX0 || w.char_code == LAT_PFX1) skip = 1'b1;
        else if (code > LAT_LO && code < LAT_HI && w.char_code != LAT_DEG) code += LAT_OFS;
      end
      if (!skip) begin
        if (w.char_code == CH_NEWLINE) begin
          col_m = 0;
          row_m = sat(row_m + 8);
        end else if (w.char_code != CH_CR) begin
          if (wrap_m && col_m + 6 > log_w()) begin
            col_m = 0;
            row_m = sat(row_m + 8);
          end
          r.drawn = render_glyph(col_m, row_m, code);
          col_m = sat(col_m + 6);
        end
      end
    end else if (w.mode == MODE_LOAD) begin
      if (w.address < GLYPH_B) begin
        glyph_m[w.address] = w.data_byte;
        glyph_set[w.address] = 1'b1;
      end
    end else if (w.mode == MODE_READ) begin
      if (w.address < FRAME_B) r.read_data = frame_m[w.address];
    end
    r.cursor_col = col_m[CUR_W-1:0];
    r.cursor_row = row_m[CUR_W-1:0];
    return r;
  endfunction

  function automatic bit glyph_loaded(int code);
    for (int i = 0; i < 5; i++)
      if (!glyph_set[code * 5 + i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic word_t mk_word(logic [1:0] m, int c, bit lat, int a, int d);
    word_t w;
    w.mode = m;
    w.char_code = c[7:0];
    w.map_latin = lat;
    w.address = a[ADDR_W-1:0];
    w.data_byte = d[7:0];
    return w;
  endfunction

  function automatic result_t mk_res(int rd, int c, int r, bit dr);
    result_t x;
    x.read_data = rd[7:0];
    x.cursor_col = c[CUR_W-1:0];
    x.cursor_row = r[CUR_W-1:0];
    x.drawn = dr;
    return x;
  endfunction

  function automatic void add_row(word_t w, bit typed, result_t want);
    row_t r;
    r.w = w;
    r.typed = typed;
    r.want = want;
    table_q.push_back(r);
  endfunction

  // character word; any glyph it draws (after mapping) is known to be loaded
  function automatic word_t random_char();
    int r, c;
    r = $urandom_range(0, 99);
    if (r < 2) return mk_word(MODE_CHAR, CH_NEWLINE, $urandom_range(0, 1), $urandom, $urandom);
    if (r < 5) return mk_word(MODE_CHAR, CH_CR, $urandom_range(0, 1), $urandom, $urandom);
    if (r < 8)
      return mk_word(MODE_CHAR, $urandom_range(0, 1) ? LAT_PFX1 : LAT_PFX0, 1'b1,
                     $urandom, $urandom);
    for (int t = 0; t < 8; t++) begin
      c = pool[$urandom_range(0, pool.size() - 1)];
      if (glyph_loaded(c)) begin
        if (c - LAT_OFS > LAT_LO && c - LAT_OFS < LAT_HI && c - LAT_OFS != LAT_DEG
            && $urandom_range(0, 1))
          return mk_word(MODE_CHAR, c - LAT_OFS, 1'b1, $urandom, $urandom);
        if ((c > LAT_LO && c < LAT_HI && c != LAT_DEG) || c == LAT_PFX0 || c == LAT_PFX1)
          return mk_word(MODE_CHAR, c, 1'b0, $urandom, $urandom);
        return mk_word(MODE_CHAR, c, $urandom_range(0, 1), $urandom, $urandom);
      end
    end
    return mk_word(MODE_CHAR, CH_CR, 1'b0, $urandom, $urandom);
  endfunction

  function automatic word_t random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      if ($urandom_range(0, 9) < 7)
        return mk_word(MODE_LOAD, $urandom, $urandom_range(0, 1),
                       pool[$urandom_range(0, pool.size() - 1)] * 5 + $urandom_range(0, 4),
                       $urandom);
      return mk_word(MODE_LOAD, $urandom, $urandom_range(0, 1), $urandom_range(0, 8191),
                     $urandom);
    end
    if (r < 75) return random_char();
    if (r < 93)
      return mk_word(MODE_READ, $urandom, $urandom_range(0, 1),
                     $urandom_range(0, 9) < 9 ? $urandom_range(0, FRAME_B - 1)
                                              : $urandom_range(0, 8191), $urandom);
    return mk_word(MODE_NONE, $urandom, $urandom_range(0, 1), $urandom_range(0, 8191),
                   $urandom);
  endfunction

  task automatic send_word(word_t w, bit typed, result_t want);
    result_t got;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= w.mode;
    in_ch.char_code <= w.char_code;
    in_ch.map_latin <= w.map_latin;
    in_ch.address   <= w.address;
    in_ch.data_byte <= w.data_byte;
    do @(posedge clk); while (!in_ch.ready);
    got = predict_word(w);
    pending_q.push_back(typed ? want : got);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    case (idx)
      REG_ROTATION: rot_m = val[1:0];
      REG_TEXT_COL: fg_m = val & 16'hFFFF;
      REG_BACK_COL: bg_m = val & 16'hFFFF;
      default:      wrap_m = val[0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int rot, int fg, int bg, int wr);
    write_reg(REG_ROTATION, rot);
    write_reg(REG_TEXT_COL, fg);
    write_reg(REG_BACK_COL, bg);
    write_reg(REG_WRAP, wr);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(negedge clk) begin
    if (recv_stall_pct != 0) out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    else out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    result_t e;
    cycles++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected word, cursor_col", out_ch.cursor_col, 0);
      end else begin
        e = pending_q.pop_front();
        if (out_ch.read_data !== e.read_data)
          report_mismatch("read_data", out_ch.read_data, e.read_data);
        if (out_ch.cursor_col !== e.cursor_col)
          report_mismatch("cursor_col", out_ch.cursor_col, e.cursor_col);
        if (out_ch.cursor_row !== e.cursor_row)
          report_mismatch("cursor_row", out_ch.cursor_row, e.cursor_row);
        if (out_ch.drawn !== e.drawn)
          report_mismatch("drawn", out_ch.drawn, e.drawn);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int settings [6][4] = '{
      '{1, 1, 0, 1},
      '{2, 16'hFFFF, 16'hFFFF, 0},
      '{3, 0, 16'h8000, 1},
      '{0, 16'h1234, 16'h1234, 0},
      '{1, 16'h5A5A, 16'h00A5, 1},
      '{0, 0, 16'hFFFF, 1}
    };
    int idle_mix [4][2] = '{'{0, 0}, '{54, 0}, '{0, 54}, '{37, 37}};
    result_t none;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_CHAR;
    in_ch.char_code = '0;
    in_ch.map_latin = 1'b0;
    in_ch.address = '0;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    foreach (frame_m[i]) frame_m[i] = 8'hFF;
    foreach (glyph_m[i]) begin
      glyph_m[i] = 8'h00;
      glyph_set[i] = 1'b0;
    end
    col_m = 0;
    row_m = 0;
    rot_m = 2'd0;
    fg_m = 0;
    bg_m = 16'hFFFF;
    wrap_m = 1'b1;
    none = mk_res(0, 0, 0, 0);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words
    add_row(mk_word(MODE_READ, 0, 0, 0, 0), 1, mk_res(8'hFF, 0, 0, 0));
    add_row(mk_word(MODE_READ, 255, 1, FRAME_B - 1, 255), 1, mk_res(8'hFF, 0, 0, 0));
    add_row(mk_word(MODE_READ, 0, 0, 8191, 0), 1, none);
    add_row(mk_word(MODE_NONE, 255, 1, 8191, 255), 1, none);
    add_row(mk_word(MODE_LOAD, 0, 0, 325, 8'hFF), 1, none);
    add_row(mk_word(MODE_LOAD, 0, 0, 326, 8'h01), 1, none);
    add_row(mk_word(MODE_LOAD, 0, 0, 327, 8'h80), 1, none);
    add_row(mk_word(MODE_LOAD, 0, 0, 328, 8'h00), 1, none);
    add_row(mk_word(MODE_LOAD, 0, 0, 329, 8'h55), 1, none);
    for (int i = 0; i < 5; i++)
      add_row(mk_word(MODE_LOAD, 0, 1, 1275 + i, 8'hAA >> i), 1, none);
    add_row(mk_word(MODE_LOAD, 0, 0, GLYPH_B, 8'hFF), 1, none);
    add_row(mk_word(MODE_LOAD, 0, 0, 8191, 8'hFF), 1, none);
    add_row(mk_word(MODE_CHAR, 65, 0, 0, 0), 0, none);
    add_row(mk_word(MODE_CHAR, 255, 1, 0, 0), 0, none);
    add_row(mk_word(MODE_CHAR, CH_CR, 0, 0, 0), 1, mk_res(0, 12, 0, 0));
    add_row(mk_word(MODE_CHAR, LAT_PFX0, 1, 0, 0), 1, mk_res(0, 12, 0, 0));
    add_row(mk_word(MODE_CHAR, LAT_PFX1, 1, 0, 0), 1, mk_res(0, 12, 0, 0));
    add_row(mk_word(MODE_READ, 0, 0, 0, 0), 0, none);
    add_row(mk_word(MODE_CHAR, CH_NEWLINE, 0, 0, 0), 1, mk_res(0, 0, 8, 0));
    add_row(mk_word(MODE_CHAR, CH_NEWLINE, 1, 0, 0), 1, mk_res(0, 0, 16, 0));
    foreach (table_q[i]) send_word(table_q[i].w, table_q[i].typed, table_q[i].want);
    drain();

    // random phases
    for (int p = 0; p < 6; p++) begin
      set_regs(settings[p][0], settings[p][1], settings[p][2], settings[p][3]);
      send_idle_pct  = idle_mix[p % 4][0];
      recv_stall_pct = idle_mix[p % 4][1];
      for (int n = 0; n < N_RANDOM; n++) begin
        // alternate busy and quiet stretches within a phase
        if (n == N_RANDOM / 2) begin
          send_idle_pct  = idle_mix[(p + 1) % 4][0];
          recv_stall_pct = idle_mix[(p + 1) % 4][1];
        end
        send_word(random_word(), 0, none);
      end
      drain();
    end

    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
